[rtl/core/lapf_pkg.sv]
// Shared types and constants for the log annulus point filter.
// Holds the input, result and circle word layouts, operation codes and
// register indexes. No dependencies.
package lapf_pkg;

  // Operation codes carried in the input word
  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_APPEND   = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;
  localparam logic [CFG_INDEX_W-1:0] CFG_CIRCLE_INCREMENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_WIDTH     = 2'd1;

  localparam logic [CFG_DATA_W-1:0] INCREMENT_RESET = 20'd20;
  localparam logic [CFG_DATA_W-1:0] BUFFER_RESET    = 20'd100;

  localparam int COORD_W = 24;
  localparam int RADIUS_W = 20;
  localparam int MATCH_W = 7;
  localparam logic [MATCH_W-1:0] MATCH_MAX = 7'd127;

  typedef struct packed {
    logic        [1:0]          operation;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic signed [COORD_W-1:0]  center_z;
    logic        [RADIUS_W-1:0] radius;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
    logic        [31:0]         point_index;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        index_out;
    logic               in_buffer;
    logic [MATCH_W-1:0] match_count;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [COORD_W-1:0]  cz;
    logic        [RADIUS_W-1:0] r;
  } circle_t;

  // Read stream from the circle memory into the evaluator
  typedef struct packed {
    logic valid;
    logic last;
  } rd_stream_t;

  // Evaluator result towards the controller
  typedef struct packed {
    logic               done;
    logic [MATCH_W-1:0] match_count;
  } eval_res_t;

endpackage

[rtl/core/lapf_circle_mem.sv]
// Circle table: one write port, one read port, registered read data.
// Depends on lapf_pkg for the circle word layout.
module lapf_circle_mem
  import lapf_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  circle_t       wdata,
  input  logic [AW-1:0] raddr,
  output circle_t       rdata
);

  circle_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/lapf_annulus_eval.sv]
// Slice and annulus test pipeline: holds the current circle and the height of the one before it,
// squares distances and radii, and counts matching slices.
// Depends on lapf_pkg.
module lapf_annulus_eval
  import lapf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] pz,
  input  logic [CFG_DATA_W-1:0]     circle_increment,
  input  logic [CFG_DATA_W-1:0]     buffer_width,
  input  rd_stream_t                rd,
  input  circle_t                   rd_data,
  output eval_res_t                 res
);

  // window
  circle_t                   cur;
  logic                      have_cur;
  logic                      cur_first;
  logic                      flush;
  logic signed [COORD_W-1:0] prev_z;
  logic signed [COORD_W-1:0] first_z;

  // window evaluation
  logic                      ev_valid;
  logic signed [COORD_W-1:0] next_z;
  logic signed [COORD_W:0]   lo;
  logic signed [COORD_W:0]   hi;
  logic signed [COORD_W:0]   pz2;
  logic signed [COORD_W:0]   dx;
  logic signed [COORD_W:0]   dy;
  logic                      slice_ok;
  logic                      range_ok;

  // stage 1
  logic                s1_vld, s1_last, s1_slice, s1_range;
  logic [COORD_W-1:0]  s1_ax, s1_ay;
  logic [20:0]         s1_rin;
  logic [21:0]         s1_rout;
  // stage 2
  logic                s2_vld, s2_last, s2_slice, s2_range;
  logic [47:0]         s2_dx2, s2_dy2;
  logic [41:0]         s2_rin2;
  logic [43:0]         s2_rout2;
  // stage 3
  logic                s3_vld, s3_last, s3_slice, s3_range;
  logic [48:0]         s3_d2;
  logic [41:0]         s3_rin2;
  logic [43:0]         s3_rout2;
  // accumulate
  logic                hit;
  logic [MATCH_W-1:0]  acc;
  logic                done;
  logic                range_q;

  assign ev_valid = (rd.valid && have_cur) || flush;
  // last circle takes its own height as the upper bound
  assign next_z   = flush ? cur.cz : rd_data.cz;
  assign lo  = cur_first ? ({cur.cz[COORD_W-1], cur.cz} + {cur.cz[COORD_W-1], cur.cz})
                         : ({cur.cz[COORD_W-1], cur.cz} + {prev_z[COORD_W-1], prev_z});
  assign hi  = {cur.cz[COORD_W-1], cur.cz} + {next_z[COORD_W-1], next_z};
  assign pz2 = {pz[COORD_W-1], pz} + {pz[COORD_W-1], pz};
  assign dx  = {px[COORD_W-1], px} - {cur.cx[COORD_W-1], cur.cx};
  assign dy  = {py[COORD_W-1], py} - {cur.cy[COORD_W-1], cur.cy};
  assign slice_ok = (pz2 >= lo) && (pz2 <= hi);
  assign range_ok = (pz >= first_z) && (pz <= cur.cz);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_cur <= 1'b0;
      flush    <= 1'b0;
    end else if (start) begin
      have_cur <= 1'b0;
      flush    <= 1'b0;
    end else begin
      flush <= rd.valid && rd.last;
      if (rd.valid) begin
        have_cur <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.valid) begin
      cur       <= rd_data;
      prev_z    <= cur.cz;
      cur_first <= !have_cur;
      if (!have_cur) begin
        first_z <= rd_data.cz;
      end
    end
  end

  // control of the pipeline stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      s1_vld <= ev_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      done   <= s3_vld && s3_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_last  <= flush;
    s1_slice <= slice_ok;
    s1_range <= range_ok;
    s1_ax    <= dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
    s1_ay    <= dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
    s1_rin   <= 21'(cur.r) + 21'(circle_increment);
    s1_rout  <= 22'(cur.r) + 22'(circle_increment) + 22'(buffer_width);

    s2_last  <= s1_last;
    s2_slice <= s1_slice;
    s2_range <= s1_range;
    s2_dx2   <= 48'(s1_ax) * 48'(s1_ax);
    s2_dy2   <= 48'(s1_ay) * 48'(s1_ay);
    s2_rin2  <= 42'(s1_rin) * 42'(s1_rin);
    s2_rout2 <= 44'(s1_rout) * 44'(s1_rout);

    s3_last  <= s2_last;
    s3_slice <= s2_slice;
    s3_range <= s2_range;
    s3_d2    <= 49'(s2_dx2) + 49'(s2_dy2);
    s3_rin2  <= s2_rin2;
    s3_rout2 <= s2_rout2;
  end

  assign hit = s3_slice && (s3_d2 > 49'(s3_rin2)) && (s3_d2 <= 49'(s3_rout2));

  always_ff @(posedge clk) begin
    if (rst || start) begin
      acc <= '0;
    end else if (s3_vld && hit && (acc != MATCH_MAX)) begin
      acc <= acc + MATCH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_vld && s3_last) begin
      range_q <= s3_range;
    end
  end

  assign res.done        = done;
  assign res.match_count = range_q ? acc : '0;

endmodule

[rtl/core/log_annulus_point_filter_core.sv]
// Log annulus point filter: circle table in one synchronous memory, classify by walking it.
// Clear and append leave in_ready high, so they can follow back to back.
// Classify with n >= 2 circles: one circle a cycle from the single read port, then a 4-stage
// test pipeline; the input reopens in the same cycle as the result word turns valid, and
// output stalls hold off both. With fewer than two circles a classify skips the walk and
// answers with no match.
// Reset clears the circle count and loads the registers with 20 and 100; table contents persist.
module log_annulus_point_filter_core
  import lapf_pkg::*;
#(
  parameter int MAX_CIRCLES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_CIRCLES);
  localparam int CW = $clog2(MAX_CIRCLES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]             circle_count;
  logic [AW-1:0]             walk_idx;
  logic [CFG_DATA_W-1:0]     circle_increment;
  logic [CFG_DATA_W-1:0]     buffer_width;

  // point under classification
  logic signed [COORD_W-1:0] pt_x, pt_y, pt_z;
  logic [31:0]               pt_index;
  logic [MATCH_W-1:0]        res_match;

  logic       accept;
  logic       is_classify;
  logic       table_room;
  logic       too_few;
  logic       walk_last;
  logic       out_free;
  logic       mem_we;
  circle_t    mem_wdata;
  circle_t    mem_rdata;
  rd_stream_t rd;
  eval_res_t  ev_res;

  assign in_ready    = (state == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign accept      = in_valid && in_ready;
  assign is_classify = (in_data.operation == OP_CLASSIFY);
  assign table_room  = (circle_count < CW'(MAX_CIRCLES));
  // fewer than two circles: answer straight away with no match
  assign too_few     = (circle_count < CW'(2));
  assign walk_last   = (CW'(walk_idx) == (circle_count - CW'(1)));
  assign out_free    = !out_valid || out_ready;

  // append writes the next free entry; a full table drops the word
  assign mem_we    = accept && (in_data.operation == OP_APPEND) && table_room;
  assign mem_wdata = '{cx: in_data.center_x, cy: in_data.center_y,
                       cz: in_data.center_z, r: in_data.radius};

  lapf_circle_mem #(
    .DEPTH (MAX_CIRCLES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (circle_count[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (walk_idx),
    .rdata (mem_rdata)
  );

  lapf_annulus_eval u_eval (
    .clk              (clk),
    .rst              (rst),
    .start            (accept && is_classify),
    .px               (pt_x),
    .py               (pt_y),
    .pz               (pt_z),
    .circle_increment (circle_increment),
    .buffer_width     (buffer_width),
    .rd               (rd),
    .rd_data          (mem_rdata),
    .res              (ev_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && is_classify) begin
          state_next = too_few ? S_OUT : S_WALK;
        end
      end
      S_WALK: begin
        if (walk_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (ev_res.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      circle_count     <= '0;
      walk_idx         <= '0;
      circle_increment <= INCREMENT_RESET;
      buffer_width     <= BUFFER_RESET;
      rd               <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CIRCLE_INCREMENT: circle_increment <= cfg_data;
          CFG_BUFFER_WIDTH:     buffer_width     <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        case (in_data.operation)
          OP_CLEAR: circle_count <= '0;
          OP_APPEND: begin
            if (table_room) begin
              circle_count <= circle_count + CW'(1);
            end
          end
          default: ;
        endcase
      end

      // advance the read address once per cycle through the walk
      if (accept) begin
        walk_idx <= '0;
      end else if (state == S_WALK) begin
        walk_idx <= walk_idx + AW'(1);
      end

      // read data lands in the cycle after the address
      rd.valid <= (state == S_WALK);
      rd.last  <= (state == S_WALK) && walk_last;

      // load a new result word when the register frees, else drop a taken one
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept && is_classify) begin
      pt_x      <= in_data.point_x;
      pt_y      <= in_data.point_y;
      pt_z      <= in_data.point_z;
      pt_index  <= in_data.point_index;
      res_match <= '0;
    end else if ((state == S_WAIT) && ev_res.done) begin
      res_match <= ev_res.match_count;
    end
    if ((state == S_OUT) && out_free) begin
      out_data.index_out   <= pt_index;
      out_data.in_buffer   <= (res_match != '0);
      out_data.match_count <= res_match;
    end
  end

endmodule

[rtl/core/lapf_checker.sv]
// Port-level checks for the log annulus point filter, bound to the top level.
// Depends on lapf_pkg.
module lapf_checker
  import lapf_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input in_word_t               in_data,
  input logic                   out_valid,
  input logic                   out_ready,
  input out_word_t              out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result word changed while stalled");

  // flag agrees with the count
  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.in_buffer == (out_data.match_count != '0)))
    else $error("in_buffer disagrees with match_count");

  // a classify word closes the input until its result is built
  a_classify_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.operation == OP_CLASSIFY)) |=> !in_ready)
    else $error("input open during classify");

  // table updates leave the input open
  a_update_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready &&
     ((in_data.operation == OP_CLEAR) || (in_data.operation == OP_APPEND))) |=> in_ready)
    else $error("input closed after table update");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind log_annulus_point_filter_core lapf_checker u_lapf_checker (.*);

[tb/sv/log_annulus_point_filter_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for log_annulus_point_filter_core: random logs of circles and points,
// with a scoreboard class that predicts every classify result. Depends on lapf_pkg and the core.
module log_annulus_point_filter_core_tb;
  import lapf_pkg::*;

  localparam int MAX_CIRCLES = 64;
  localparam int ITEMS_TOTAL = 1100;
  localparam int N_PHASES = 7;
  // Quiet cycles once the last result is in; covers a full walk of the table
  localparam int SETTLE_CYCLES = 2 * MAX_CIRCLES + 16;
  // Long receiver hold-off, so the block fills and stops taking words
  localparam int HOLD_CYCLES = 600;
  localparam int MAX_PRINTED = 60;
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  // Opcode and register indexes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Rough unit directions, sixteenths
  localparam int DIR_A [8] = '{16, 0, -16, 0, 11, -11, 11, -11};
  localparam int DIR_B [8] = '{0, 16, 0, -16, 11, 11, -11, -11};

  // Predicts the classify results from the words the block has taken,
  // and holds them in order until the block hands them out.
  class annulus_scoreboard;
    circle_t               circles [MAX_CIRCLES];
    int unsigned           n_stored;
    logic [CFG_DATA_W-1:0] circle_inc;
    logic [CFG_DATA_W-1:0] annulus_width;
    out_word_t             expected_q [$];
    int                    errors;

    function new();
      n_stored      = 0;
      circle_inc    = INCREMENT_RESET;
      annulus_width = BUFFER_RESET;
      errors        = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(input string what);
      if (errors < MAX_PRINTED) $display("mismatch @%0t: %s", $realtime, what);
      errors++;
    endtask

    function void set_register(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_CIRCLE_INCREMENT) circle_inc = val;
      else if (idx == CFG_BUFFER_WIDTH) annulus_width = val;
    endfunction

    // Count the slices whose annulus holds the point
    function int unsigned count_matches(input in_word_t w);
      longint px, py, pz, pz2, lo, hi, dx, dy, d2, rin, rout;
      int unsigned hits;
      hits = 0;
      px = longint'($signed(w.point_x));
      py = longint'($signed(w.point_y));
      pz = longint'($signed(w.point_z));
      pz2 = 2 * pz;
      if (n_stored < 2) return 0;
      // outside the log's height span, or first circle above the last
      if (pz < longint'($signed(circles[0].cz))) return 0;
      if (pz > longint'($signed(circles[n_stored - 1].cz))) return 0;
      for (int i = 0; i < n_stored; i++) begin
        // slice bounds in doubled units, so midpoints stay exact
        lo = 2 * longint'($signed(circles[i].cz));
        hi = lo;
        if (i > 0) lo = longint'($signed(circles[i].cz)) + longint'($signed(circles[i - 1].cz));
        if (i + 1 < n_stored)
          hi = longint'($signed(circles[i].cz)) + longint'($signed(circles[i + 1].cz));
        if (pz2 < lo || pz2 > hi) continue;
        rin  = longint'(circles[i].r) + longint'(circle_inc);
        rout = rin + longint'(annulus_width);
        dx = px - longint'($signed(circles[i].cx));
        dy = py - longint'($signed(circles[i].cy));
        d2 = dx * dx + dy * dy;
        if (d2 > rin * rin && d2 <= rout * rout) begin
          if (hits < MATCH_MAX) hits++;
        end
      end
      return hits;
    endfunction

    // Advance the predicted state by one accepted input word
    function void note_word(input in_word_t w);
      out_word_t e;
      int unsigned hits;
      case (w.operation)
        OP_CLEAR: begin
          n_stored = 0;
        end
        OP_APPEND: begin
          // a full table drops further circles
          if (n_stored < MAX_CIRCLES) begin
            circles[n_stored].cx = w.center_x;
            circles[n_stored].cy = w.center_y;
            circles[n_stored].cz = w.center_z;
            circles[n_stored].r  = w.radius;
            n_stored++;
          end
        end
        OP_CLASSIFY: begin
          hits = count_matches(w);
          e.index_out   = w.point_index;
          e.in_buffer   = (hits != 0);
          e.match_count = MATCH_W'(hits);
          expected_q.push_back(e);
        end
        default: begin
        end
      endcase
    endfunction

    task check_result(input out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, index %0d", got.index_out));
        return;
      end
      want = expected_q.pop_front();
      if (got.index_out !== want.index_out)
        report_mismatch($sformatf("index_out %0d, want %0d", got.index_out, want.index_out));
      if (got.in_buffer !== want.in_buffer)
        report_mismatch($sformatf("in_buffer %b, want %b (index %0d)",
                                  got.in_buffer, want.in_buffer, want.index_out));
      if (got.match_count !== want.match_count)
        report_mismatch($sformatf("match_count %0d, want %0d (index %0d)",
                                  got.match_count, want.match_count, want.index_out));
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_word_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_word_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  annulus_scoreboard sb = new();
  int   items_sent = 0;
  bit   idle_on = 1'b1;
  int   phase_no = 0;
  logic hold_off = 1'b0;

  log_annulus_point_filter_core #(
    .MAX_CIRCLES(MAX_CIRCLES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every field random; callers override what the operation uses
  function automatic in_word_t random_word();
    in_word_t w;
    w.operation   = 2'($urandom_range(0, 3));
    w.center_x    = COORD_W'($urandom);
    w.center_y    = COORD_W'($urandom);
    w.center_z    = COORD_W'($urandom);
    w.radius      = RADIUS_W'($urandom);
    w.point_x     = COORD_W'($urandom);
    w.point_y     = COORD_W'($urandom);
    w.point_z     = COORD_W'($urandom);
    w.point_index = $urandom;
    return w;
  endfunction

  // Offer one word and hold it until taken. Valid stays high afterwards, so
  // back-to-back words never drop it; a gap lowers it first.
  task automatic send_word(input in_word_t w);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    if (w.operation != OP_UNUSED) items_sent++;
  endtask

  task automatic send_op(input logic [1:0] op);
    in_word_t w;
    w = random_word();
    w.operation = op;
    send_word(w);
  endtask

  task automatic send_circle(input int x, input int y, input int z, input int r);
    in_word_t w;
    w = random_word();
    w.operation = OP_APPEND;
    w.center_x  = COORD_W'(x);
    w.center_y  = COORD_W'(y);
    w.center_z  = COORD_W'(z);
    w.radius    = RADIUS_W'(r);
    send_word(w);
  endtask

  task automatic send_point(input int x, input int y, input int z, input logic [31:0] idx);
    in_word_t w;
    w = random_word();
    w.operation   = OP_CLASSIFY;
    w.point_x     = COORD_W'(x);
    w.point_y     = COORD_W'(y);
    w.point_z     = COORD_W'(z);
    w.point_index = idx;
    send_word(w);
  endtask

  // Keeps cfg_valid high; the caller drops it after the last write
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
  endtask

  // Drain the block, let a trailing append settle, write the spare indexes when asked, then load both registers
  task automatic configure(input logic [CFG_DATA_W-1:0] inc, input logic [CFG_DATA_W-1:0] bw,
                           input bit with_spare);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (with_spare) begin
      write_register(CFG_SPARE_LO, CFG_DATA_W'($urandom));
      write_register(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    end
    write_register(CFG_CIRCLE_INCREMENT, inc);
    write_register(CFG_BUFFER_WIDTH, bw);
    cfg_valid <= 1'b0;
  endtask

  // One log: clear, a stack of circles, then points aimed at the annuli.
  // Noise words and odd logs (none, one, full table, falling heights) are mixed in.
  task automatic run_log();
    int  lx [80];
    int  ly [80];
    int  lz [80];
    int  lr [80];
    int  n, n_eff, m, pick, base_x, base_y, z, step, j, d, dir, rin, rw;
    bit  falling;
    in_word_t w;
    pick = $urandom_range(0, 19);
    if (pick == 0) n = 0;
    else if (pick == 1) n = 1;
    else if (pick == 2) n = $urandom_range(60, 70);
    else n = $urandom_range(2, 8);
    n_eff = (n > MAX_CIRCLES) ? MAX_CIRCLES : n;
    m = $urandom_range(4, 16);
    falling = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 7) == 0) begin
      base_x = $urandom;
      base_y = $urandom;
    end else begin
      base_x = int'($urandom_range(0, 2000000)) - 1000000;
      base_y = int'($urandom_range(0, 2000000)) - 1000000;
    end
    z = int'($urandom_range(0, 200000)) - 100000;

    send_op(OP_CLEAR);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 14) == 0) send_word(random_word());
      w = random_word();
      w.operation = OP_APPEND;
      w.center_x  = COORD_W'(base_x + int'($urandom_range(0, 400)) - 200);
      w.center_y  = COORD_W'(base_y + int'($urandom_range(0, 400)) - 200);
      w.center_z  = COORD_W'(z);
      if ($urandom_range(0, 15) != 0) w.radius = RADIUS_W'($urandom_range(50, 600));
      // hold what the block really stores, after truncation
      lx[k] = int'($signed(w.center_x));
      ly[k] = int'($signed(w.center_y));
      lz[k] = int'($signed(w.center_z));
      lr[k] = int'(w.radius);
      send_word(w);
      // equal heights now and then give overlapping slices
      step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : $urandom_range(100, 1500);
      z = falling ? z - step : z + step;
    end

    for (int k = 0; k < m; k++) begin
      if ($urandom_range(0, 14) == 0) send_word(random_word());
      w = random_word();
      w.operation = OP_CLASSIFY;
      if (n_eff > 0 && $urandom_range(0, 9) != 0) begin
        j   = $urandom_range(0, n_eff - 1);
        rin = lr[j] + int'(sb.circle_inc);
        rw  = int'(sb.annulus_width);
        dir = $urandom_range(0, 7);
        case ($urandom_range(0, 7))
          0: begin
            // land on one of the ring edges, axis aligned
            dir = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
              0: d = rin;
              1: d = rin + 1;
              2: d = rin + rw;
              default: d = rin + rw + 1;
            endcase
          end
          default: begin
            d = rin + int'($urandom_range(0, rw + 60)) - 30;
          end
        endcase
        w.point_x = COORD_W'(lx[j] + d * DIR_A[dir] / 16);
        w.point_y = COORD_W'(ly[j] + d * DIR_B[dir] / 16);
        w.point_z = COORD_W'(lz[j] + int'($urandom_range(0, 1600)) - 800);
      end
      send_word(w);
    end
  endtask

  // Receiver: check every taken result word, stall in short bursts
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_data);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
      out_ready <= !(hold_off || stall_left > 0);
    end
  end

  // One long hold-off early in the second phase while the sender keeps going
  initial begin : pressure
    wait (phase_no == 2);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("log_annulus_point_filter_core_tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] inc, bw;
    int target;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CIRCLE_INCREMENT;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words on the reset register values (increment 20, width 100)
    send_point(1021, 0, 0, 32'd0);                 // empty table
    send_op(OP_UNUSED);
    send_op(OP_CLEAR);
    send_circle(0, 0, 0, 1000);
    send_point(1021, 0, 0, $urandom);              // only one circle
    send_circle(0, 0, 1000, 1000);
    send_point(1021, 0, 0, $urandom);              // bottom slice only
    send_point(0, 1120, 500, 32'hFFFF_FFFF);       // outer edge, both slices
    send_point(1020, 0, 500, $urandom);            // inner edge is excluded
    send_point(-1121, 0, 1000, $urandom);          // just past the outer edge
    send_point(0, -1050, -1, $urandom);            // below the first circle
    send_op(OP_UNUSED);
    send_op(OP_CLEAR);
    // first circle above the last: nothing can match
    send_circle(8388607, -8388608, 8388607, 1048575);
    send_circle(-8388608, 8388607, -8388608, 0);
    send_point(0, 0, 0, $urandom);
    send_op(OP_CLEAR);
    send_circle(-8388608, -8388608, -8388608, 1048575);
    send_circle(8388607, 8388607, 8388607, 0);
    send_point(-8388608, -7339983, -8388608, $urandom);
    send_point(8388607, 8388607, 8388607, $urandom);
    send_point(8388607, 8388587, 8388607, $urandom);

    for (int p = 1; p <= N_PHASES; p++) begin
      case (p)
        1: begin
          inc = '0;
          bw  = '0;
        end
        2: begin
          inc = '1;
          bw  = '1;
        end
        3: begin
          inc = '0;
          bw  = '1;
        end
        4: begin
          inc = '1;
          bw  = '0;
        end
        5: begin
          inc = CFG_DATA_W'($urandom_range(0, 100));
          bw  = CFG_DATA_W'($urandom_range(0, 400));
        end
        6: begin
          inc = CFG_DATA_W'($urandom);
          bw  = CFG_DATA_W'($urandom);
        end
        default: begin
          inc = CFG_DATA_W'($urandom_range(0, 50));
          bw  = CFG_DATA_W'($urandom_range(50, 300));
        end
      endcase
      configure(inc, bw, p == 6);
      phase_no = p;
      target = ITEMS_TOTAL * p / N_PHASES;
      while (items_sent < target) begin
        // the last phase runs flat out on both sides
        idle_on = (p != N_PHASES) && ($urandom_range(0, 4) != 0);
        run_log();
      end
    end

    // Drain and let the block go quiet before the verdict
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("log_annulus_point_filter_core_tb: clean");
    end else begin
      $display("log_annulus_point_filter_core_tb: errors");
    end
    $finish;
  end

endmodule

[log_annulus_point_filter_core.f]
rtl/core/lapf_pkg.sv
rtl/core/lapf_circle_mem.sv
rtl/core/lapf_annulus_eval.sv
rtl/core/log_annulus_point_filter_core.sv
rtl/core/lapf_checker.sv
tb/sv/log_annulus_point_filter_core_tb.sv
